// ===== hw/rtl/fsp_pkg.sv =====
`timescale 1ns / 1ps

package fsp_pkg;

   // Field widths
   localparam int SLOT_W  = 12;
   localparam int BLOCK_W = 13;
   localparam int ADDR_W  = 16;
   localparam int COUNT_W = 12;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = BLOCK_W;
   localparam logic [CSR_INDEX_W-1:0] REG_SLOT_BYTES  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_BYTES = 1'd1;

   // Register reset values and the slot count that follows from them
   localparam int RESET_SLOT_BYTES  = 16;
   localparam int RESET_BLOCK_BYTES = 4096;
   localparam int RESET_SLOTS_INT   = (RESET_BLOCK_BYTES - RESET_SLOT_BYTES) / RESET_SLOT_BYTES;
   localparam logic [COUNT_W-1:0] RESET_SLOTS = COUNT_W'(RESET_SLOTS_INT);

   // Slot count saturates at the counter's full range
   localparam logic [COUNT_W-1:0] SLOTS_MAX = '1;

   // Largest slot size that cannot be recycled
   localparam logic [SLOT_W-1:0] MIN_FREE_SLOT = 12'd4;

   // Divider runs one quotient bit per cycle
   localparam int DIV_STEPS = BLOCK_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // Operation codes
   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_BLOCKS  = 2'd1,
      ST_FREE_SMALL = 2'd2,
      ST_FREE_FULL  = 2'd3
   } status_type;

endpackage

// ===== hw/rtl/fsp_slot_div.sv =====
`timescale 1ns / 1ps

module fsp_slot_div
   import fsp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SLOT_W-1:0]  slot_bytes,
   input  logic [BLOCK_W-1:0] block_bytes,
   output logic               busy,
   output logic               done,
   output logic [COUNT_W-1:0] slots
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic                 zero_ff, zero_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [BLOCK_W-1:0]   quo_ff, quo_in;
   logic [SLOT_W-1:0]    rem_ff, rem_in;
   logic [SLOT_W-1:0]    div_ff, div_in;
   logic [BLOCK_W-1:0]   trial;
   logic [BLOCK_W-1:0]   diff;
   logic                 fits;

   // Shift in one dividend bit and try the subtract
   assign trial = {rem_ff, quo_ff[BLOCK_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         // load dividend (block - slot) and divisor
         run_in  = 1'b1;
         zero_in = (slot_bytes == '0) || (block_bytes <= {1'b0, slot_bytes});
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         quo_in  = block_bytes - {1'b0, slot_bytes};
         rem_in  = '0;
         div_in  = slot_bytes;
      end else if (run_ff) begin
         // one restoring step per cycle
         rem_in = fits ? diff[SLOT_W-1:0] : trial[SLOT_W-1:0];
         quo_in = {quo_ff[BLOCK_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   // Saturate the quotient; degenerate sizes give no slots
   always_comb begin
      if (zero_ff) begin
         slots = '0;
      end else if (quo_ff[BLOCK_W-1]) begin
         slots = SLOTS_MAX;
      end else begin
         slots = quo_ff[COUNT_W-1:0];
      end
   end

   assign busy = run_ff || done_ff;
   assign done = done_ff;

endmodule

// ===== hw/rtl/fsp_stack_ram.sv =====
`timescale 1ns / 1ps

module fsp_stack_ram
   import fsp_pkg::*;
#(
   parameter int DEPTH = 64
)(
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_index,
   input  logic [ADDR_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_index,
   output logic [ADDR_W-1:0]        rd_data
);

   logic [ADDR_W-1:0] mem_ff [DEPTH];
   logic [ADDR_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_index] <= wr_data;
      end
   end

   // Registered read port, held between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_index];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/fixed_slot_pool_allocator.sv =====
`timescale 1ns / 1ps
// An accepted request passes through the middle stage, then the response register.
// Throughput: one request per cycle unless a configuration write or a response stall holds them.
// A new request can enter an empty middle stage while the response waits. A configuration write
// stalls requests while the one-bit-per-cycle divider works out the slot count per block.
// Reset (synchronous) restores the registers and empties pool and stack; stack contents stay.

module fixed_slot_pool_allocator
   import fsp_pkg::*;
#(
   parameter int MAX_BLOCKS = 16,
   parameter int FREE_DEPTH = 64
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_operation,
   input  logic [ADDR_W-1:0]      req_free_address,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ADDR_W-1:0]      rsp_address,
   output logic                   rsp_new_block,
   output logic [1:0]             rsp_status,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int BLK_W = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W = $clog2(FREE_DEPTH);
   localparam int CNT_W = $clog2(FREE_DEPTH + 1);

   // Configuration and allocator state
   logic [SLOT_W-1:0]  slot_bytes_ff, slot_bytes_in;
   logic [BLOCK_W-1:0] block_bytes_ff, block_bytes_in;
   logic               start_ff;
   logic [COUNT_W-1:0] slots_per_block_ff, slots_per_block_in;
   logic [COUNT_W-1:0] uses_in_block_ff, uses_in_block_in;
   logic [ADDR_W-1:0]  bump_address_ff, bump_address_in;
   logic [BLK_W-1:0]   blocks_in_use_ff, blocks_in_use_in;
   logic [CNT_W-1:0]   freed_count_ff, freed_count_in;

   // Middle stage and response register
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_from_mem_ff, s1_from_mem_in;
   logic [ADDR_W-1:0]  s1_address_ff, s1_address_in;
   logic               s1_new_block_ff, s1_new_block_in;
   status_type         s1_status_ff, s1_status_in;
   logic               rsp_valid_ff;
   logic [ADDR_W-1:0]  rsp_address_ff;
   logic               rsp_new_block_ff;
   status_type         rsp_status_ff;

   logic               div_busy;
   logic               div_done;
   logic [COUNT_W-1:0] div_slots;
   logic               cfg_busy;
   logic               s1_advance;
   logic               s1_load;
   logic               req_accept;
   logic               push;
   logic               pop;
   logic [CNT_W-1:0]   pop_count;
   logic [BLK_W+BLOCK_W-1:0] base_full;
   logic [ADDR_W-1:0]  base;
   logic [ADDR_W-1:0]  stack_rd_data;

   // Handshake
   assign cfg_busy   = csr_write_enable || start_ff || div_busy;
   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign s1_load    = s1_advance || !s1_valid_ff;
   assign req_stall  = cfg_busy || !s1_load;
   assign req_accept = req_valid && !req_stall;

   // Configuration writes
   always_comb begin
      slot_bytes_in  = slot_bytes_ff;
      block_bytes_in = block_bytes_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_SLOT_BYTES:  slot_bytes_in  = csr_write_data[SLOT_W-1:0];
            REG_BLOCK_BYTES: block_bytes_in = csr_write_data;
            default:         slot_bytes_in  = slot_bytes_ff;
         endcase
      end
   end

   fsp_slot_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (start_ff),
      .slot_bytes  (slot_bytes_ff),
      .block_bytes (block_bytes_ff),
      .busy        (div_busy),
      .done        (div_done),
      .slots       (div_slots)
   );

   assign slots_per_block_in = div_done ? div_slots : slots_per_block_ff;

   // Base of the next pool block
   assign base_full = blocks_in_use_ff * block_bytes_ff;
   assign base      = ADDR_W'(base_full);
   assign pop_count = freed_count_ff - 1'b1;

   // Allocate and free decisions
   always_comb begin
      uses_in_block_in = uses_in_block_ff;
      bump_address_in  = bump_address_ff;
      blocks_in_use_in = blocks_in_use_ff;
      freed_count_in   = freed_count_ff;
      s1_from_mem_in   = 1'b0;
      s1_address_in    = '0;
      s1_new_block_in  = 1'b0;
      s1_status_in     = ST_OK;
      push             = 1'b0;
      pop              = 1'b0;
      unique case (op_type'(req_operation))
         OP_ALLOC: begin
            priority if (uses_in_block_ff < slots_per_block_ff) begin
               // bump through the current block
               s1_address_in    = bump_address_ff;
               bump_address_in  = bump_address_ff + ADDR_W'(slot_bytes_ff);
               uses_in_block_in = uses_in_block_ff + 1'b1;
            end else if (freed_count_ff != '0) begin
               // pop the last freed slot
               pop            = 1'b1;
               s1_from_mem_in = 1'b1;
               freed_count_in = pop_count;
            end else begin
               // open the next pool block
               s1_new_block_in = (blocks_in_use_ff != '0);
               if (blocks_in_use_ff < BLK_W'(MAX_BLOCKS)) begin
                  s1_address_in    = base;
                  blocks_in_use_in = blocks_in_use_ff + 1'b1;
                  uses_in_block_in = COUNT_W'(1);
                  bump_address_in  = base + ADDR_W'(slot_bytes_ff);
               end else begin
                  s1_status_in = ST_NO_BLOCKS;
               end
            end
         end
         OP_FREE: begin
            priority if (slot_bytes_ff <= MIN_FREE_SLOT) begin
               s1_status_in = ST_FREE_SMALL;
            end else if (freed_count_ff < CNT_W'(FREE_DEPTH)) begin
               push           = 1'b1;
               freed_count_in = freed_count_ff + 1'b1;
            end else begin
               s1_status_in = ST_FREE_FULL;
            end
         end
         default: s1_status_in = ST_OK;
      endcase
   end

   assign s1_valid_in = req_accept;

   fsp_stack_ram #(
      .DEPTH (FREE_DEPTH)
   ) u_stack (
      .clock    (clock),
      .wr_en    (req_accept && push),
      .wr_index (freed_count_ff[IDX_W-1:0]),
      .wr_data  (req_free_address),
      .rd_en    (req_accept && pop),
      .rd_index (pop_count[IDX_W-1:0]),
      .rd_data  (stack_rd_data)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_bytes_ff      <= SLOT_W'(RESET_SLOT_BYTES);
         block_bytes_ff     <= BLOCK_W'(RESET_BLOCK_BYTES);
         start_ff           <= 1'b0;
         slots_per_block_ff <= RESET_SLOTS;
         uses_in_block_ff   <= RESET_SLOTS;
         bump_address_ff    <= '0;
         blocks_in_use_ff   <= '0;
         freed_count_ff     <= '0;
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         slot_bytes_ff      <= slot_bytes_in;
         block_bytes_ff     <= block_bytes_in;
         start_ff           <= csr_write_enable;
         slots_per_block_ff <= slots_per_block_in;
         if (req_accept) begin
            uses_in_block_ff <= uses_in_block_in;
            bump_address_ff  <= bump_address_in;
            blocks_in_use_ff <= blocks_in_use_in;
            freed_count_ff   <= freed_count_in;
         end
         if (s1_load) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (s1_advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Payload of the middle stage and the response register
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_from_mem_ff  <= s1_from_mem_in;
         s1_address_ff   <= s1_address_in;
         s1_new_block_ff <= s1_new_block_in;
         s1_status_ff    <= s1_status_in;
      end
      if (s1_advance) begin
         rsp_address_ff   <= s1_from_mem_ff ? stack_rd_data : s1_address_ff;
         rsp_new_block_ff <= s1_new_block_ff;
         rsp_status_ff    <= s1_status_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_address   = rsp_address_ff;
   assign rsp_new_block = rsp_new_block_ff;
   assign rsp_status    = rsp_status_ff;

endmodule
